[hw/rtl/pqes_pkg.sv]
// Package for the planar quadrotor Euler step block.
// Holds fixed-point constants, the CORDIC arctangent table and sequencer codes.
// No dependencies.
package pqes_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int MAX_STEPS        = 24;

	localparam logic signed [33:0] K_Q30       = 34'sd652032874;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [35:0] G_Q30       = 36'sd10533407293;

	localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [47:0] ERR_MAX = 48'hFFFF_FFFF_FFFF;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		logic signed [33:0] r;
		begin
			unique case (i)
				5'd0:  r = 34'sd843314856;
				5'd1:  r = 34'sd497837829;
				5'd2:  r = 34'sd263043836;
				5'd3:  r = 34'sd133525158;
				5'd4:  r = 34'sd67021686;
				5'd5:  r = 34'sd33543515;
				5'd6:  r = 34'sd16775850;
				5'd7:  r = 34'sd8388437;
				5'd8:  r = 34'sd4194282;
				5'd9:  r = 34'sd2097149;
				5'd10: r = 34'sd1048575;
				5'd11: r = 34'sd524287;
				5'd12: r = 34'sd262143;
				5'd13: r = 34'sd131071;
				5'd14: r = 34'sd65535;
				5'd15: r = 34'sd32767;
				5'd16: r = 34'sd16383;
				5'd17: r = 34'sd8191;
				5'd18: r = 34'sd4095;
				5'd19: r = 34'sd2047;
				5'd20: r = 34'sd1023;
				5'd21: r = 34'sd511;
				5'd22: r = 34'sd255;
				5'd23: r = 34'sd127;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		begin
			if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
			else if (v < -66'sd2147483648) return 32'sh8000_0000;
			else return v[31:0];
		end
	endfunction

	// Sequencer states of the top level.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CORD  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_ERR   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

endpackage

[hw/rtl/pqes_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q4.30.
// Depends on pqes_pkg.
module pqes_cordic #(
	parameter int CORDIC_STEPS = pqes_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [33:0]  angle,
	output logic                done,
	output logic signed [33:0]  sin_out,
	output logic signed [33:0]  cos_out
);
	import pqes_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [4:0]         i_q;
	logic signed [33:0] xs, ys, z0;
	logic               f0;

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		if (angle > HALF_PI_Q30) begin
			z0 = PI_Q30 - angle; f0 = 1'b1;
		end else if (angle < -HALF_PI_Q30) begin
			z0 = -PI_Q30 - angle; f0 = 1'b1;
		end else begin
			z0 = angle; f0 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q <= K_Q30; y_q <= '0; z_q <= z0; flip_q <= f0;
				i_q <= '0; busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_q30(i_q);
				end else begin
					x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_q30(i_q);
				end
				if (i_q == 5'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	assign sin_out = y_q;
	assign cos_out = flip_q ? -x_q : x_q;

endmodule

[hw/rtl/planar_quad_euler_step_with_cost.sv]
// Top level of the planar quadrotor Euler step with run cost.
// Depends on pqes_pkg and pqes_cordic.
//
// One transaction in gives one transaction out. An accepted item first runs
// the CORDIC unit for sine and cosine and then hands over to six steps
// through one shared 34x34 multiplier (thrust times sine and cosine, then
// four products with the time step); a last item takes four more steps for
// the squared errors. The result then waits in the output register. The
// CORDIC loop and the single multiplier set how long an item takes. The block
// accepts no item while one is in flight. Configuration registers are written
// by cfg_we/cfg_index/cfg_data; the user must write them only while idle, as
// the block itself does not enforce it.
module planar_quad_euler_step_with_cost #(
	parameter int FRAC_BITS    = pqes_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = pqes_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  thrust,
	input  logic signed [18:0]  pitch,
	input  logic [16:0]         time_step,
	input  logic                run_first,
	input  logic                run_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  vel_x,
	output logic signed [31:0]  pos_z,
	output logic signed [31:0]  vel_z,
	output logic [39:0]         thrust_change_total,
	output logic [39:0]         pitch_change_total,
	output logic [39:0]         thrust_magnitude_total,
	output logic [47:0]         distance_error,
	output logic [47:0]         velocity_error,
	output logic                run_done
);
	import pqes_pkg::*;

	localparam logic signed [33:0] G_FIX = 34'(G_Q30 >>> (30 - FRAC_BITS));

	logic signed [31:0] cfg_q [8];
	logic [2:0]  st_q;
	logic [3:0]  k_q;
	logic signed [31:0] thr_q, pthr_q;
	logic signed [18:0] pit_q, ppit_q;
	logic [16:0] dt_q;
	logic        first_q, last_q;
	logic signed [31:0] px_q, vx_q, pz_q, vz_q;
	logic [39:0] s_tc_q, s_pc_q, s_tm_q;
	logic signed [33:0] ax_q, az_q;
	logic [47:0] de_q, ve_q;
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic        cord_done;
	logic signed [33:0] sn, cs;
	logic signed [32:0] ddx;

	pqes_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n),
		.start(in_valid && in_ready),
		.angle(34'(pitch) <<< (30 - FRAC_BITS)),
		.done(cord_done), .sin_out(sn), .cos_out(cs)
	);

	// Shared multiplier operand selection per sequencer step.
	always_comb begin
		ma = '0; mb = '0; ddx = '0;
		unique case (k_q)
			4'd0: begin ma = 34'(thr_q); mb = sn; end
			4'd1: begin ma = 34'(thr_q); mb = cs; end
			4'd2: begin ma = 34'(vx_q); mb = 34'($signed({1'b0, dt_q})); end
			4'd3: begin ma = 34'(vz_q); mb = 34'($signed({1'b0, dt_q})); end
			4'd4: begin ma = ax_q; mb = 34'($signed({1'b0, dt_q})); end
			4'd5: begin ma = az_q; mb = 34'($signed({1'b0, dt_q})); end
			4'd6: ddx = 33'(px_q) - 33'(cfg_q[4]);
			4'd7: ddx = 33'(pz_q) - 33'(cfg_q[6]);
			4'd8: ddx = 33'(vx_q) - 33'(cfg_q[5]);
			4'd9: ddx = 33'(vz_q) - 33'(cfg_q[7]);
			default: ;
		endcase
		if (k_q >= 4'd6) begin
			ma = 34'(ddx); mb = 34'(ddx);
		end
		prod = ma * mb;
	end

	logic signed [67:0] prod_sh;
	logic [47:0] sq;
	logic [48:0] esum;
	assign prod_sh = prod >>> FRAC_BITS;
	always_comb begin
		if (prod_sh > 68'sd281474976710655) sq = ERR_MAX;
		else sq = prod_sh[47:0];
		// Position errors come first, velocity errors in the last two steps.
		esum = (k_q == 4'd6 || k_q == 4'd7) ? {1'b0, de_q} + {1'b0, sq}
			: {1'b0, ve_q} + {1'b0, sq};
	end

	function automatic logic [39:0] sadd(input logic [39:0] a, input logic [32:0] b);
		logic [40:0] s;
		begin
			s = {1'b0, a} + 41'(b);
			return s[40] ? SUM_MAX : s[39:0];
		end
	endfunction

	logic signed [32:0] dth, dpt;
	logic [32:0] adth, adpt, athr;
	always_comb begin
		dth  = 33'(thr_q) - 33'(pthr_q);
		dpt  = 33'(pit_q) - 33'(ppit_q);
		adth = dth[32] ? 33'(-dth) : 33'(dth);
		adpt = dpt[32] ? 33'(-dpt) : 33'(dpt);
		athr = thr_q[31] ? 33'(-34'(thr_q)) : 33'(thr_q);
	end

	assign in_ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cfg_q[i] <= '0;
			st_q <= ST_IDLE; k_q <= '0; out_valid <= 1'b0;
			px_q <= '0; vx_q <= '0; pz_q <= '0; vz_q <= '0;
			pthr_q <= '0; ppit_q <= '0;
			s_tc_q <= '0; s_pc_q <= '0; s_tm_q <= '0;
		end else begin
			if (cfg_we) cfg_q[cfg_index] <= cfg_data;
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					thr_q <= thrust; pit_q <= pitch; dt_q <= time_step;
					first_q <= run_first; last_q <= run_last;
					if (run_first) begin
						px_q <= cfg_q[0]; vx_q <= cfg_q[1];
						pz_q <= cfg_q[2]; vz_q <= cfg_q[3];
						s_tc_q <= '0; s_pc_q <= '0; s_tm_q <= '0;
					end
					k_q <= '0; de_q <= '0; ve_q <= '0;
					st_q <= ST_CORD;
				end
				ST_CORD: if (cord_done) st_q <= ST_MUL;
				ST_MUL: begin
					k_q <= k_q + 4'd1;
					unique case (k_q)
						4'd0: ax_q <= 34'(prod >>> 30);
						4'd1: az_q <= 34'(prod >>> 30) - G_FIX;
						4'd2: px_q <= sat32(66'(px_q) + 66'(prod_sh));
						4'd3: pz_q <= sat32(66'(pz_q) + 66'(prod_sh));
						4'd4: vx_q <= sat32(66'(vx_q) + 66'(prod_sh));
						default: begin
							vz_q <= sat32(66'(vz_q) + 66'(prod_sh));
							if (!first_q) begin
								s_tc_q <= sadd(s_tc_q, adth);
								s_pc_q <= sadd(s_pc_q, adpt);
								s_tm_q <= sadd(s_tm_q, athr);
							end
							pthr_q <= thr_q; ppit_q <= pit_q;
							st_q <= last_q ? ST_ERR : ST_OUT;
							out_valid <= !last_q;
						end
					endcase
				end
				ST_ERR: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd6 || k_q == 4'd7) de_q <= esum[48] ? ERR_MAX : esum[47:0];
					else ve_q <= esum[48] ? ERR_MAX : esum[47:0];
					if (k_q == 4'd9) begin
						st_q <= ST_OUT; out_valid <= 1'b1;
					end
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign pos_x = px_q;
	assign vel_x = vx_q;
	assign pos_z = pz_q;
	assign vel_z = vz_q;
	assign thrust_change_total    = s_tc_q;
	assign pitch_change_total     = s_pc_q;
	assign thrust_magnitude_total = s_tm_q;
	assign distance_error = de_q;
	assign velocity_error = ve_q;
	assign run_done       = last_q;

endmodule

[hw/rtl/pqes_checker.sv]
// Port-level checker for the planar quadrotor step block, with its bind.
// Depends on nothing but the top level's ports.
module pqes_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        run_done,
	input logic [47:0] distance_error
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_done |-> distance_error == 48'd0) else $error("error not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind planar_quad_euler_step_with_cost pqes_props u_pqes_props (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .run_done(run_done),
	.distance_error(distance_error)
);
